[rtl/mts_pkg.sv]
// Shared types, constants and helpers for the multipart transfer session block.
// No dependencies; imported by mts_alu and multipart_transfer_sessions_top.
`default_nettype none

package mts_pkg;

    localparam int SESSION_ENTRIES = 8;
    localparam int CHECKSUM_BYTES  = 4;
    localparam int IDX_W = (SESSION_ENTRIES > 1) ? $clog2(SESSION_ENTRIES) : 1;
    localparam int CNT_W = $clog2(SESSION_ENTRIES + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] HANDLE_TOP_BIT  = 32'h8000_0000;
    localparam logic [31:0] DEFAULT_TIMEOUT = 32'd60000;
    localparam logic [11:0] DEFAULT_CHUNK   = 12'd56;
    localparam logic [7:0]  FLAG_GET_FIRST  = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_LENGTH    = 2'd0,
        CFG_CHUNK_CAPACITY  = 2'd1,
        CFG_SESSION_TIMEOUT = 2'd2,
        CFG_TABLE_CRC       = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK             = 2'd0,
        ST_BAD_FLAG       = 2'd1,
        ST_UNKNOWN_HANDLE = 2'd2,
        ST_NO_SESSION     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        KIND_START     = 3'd1,
        KIND_MIDDLE    = 3'd2,
        KIND_END       = 3'd4,
        KIND_START_END = 3'd5
    } t_kind;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    // carry is the carry out for ADD and the borrow for SUB
    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
    } t_alu_rsp;

    typedef struct packed {
        logic [31:0] handle;
        logic [15:0] offset;
        logic [31:0] expiry;
    } t_entry;

    typedef struct packed {
        t_status     status;
        logic [31:0] next_handle;
        t_kind       kind;
        logic [15:0] offset;
        logic [11:0] length;
        logic        crc_present;
        logic [31:0] crc;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIT,
        S_SCAN,
        S_NEW_CNT,
        S_NEW_EXP,
        S_REM,
        S_CMP,
        S_ADV,
        S_TOUCH,
        S_EMIT
    } t_state;

    // Start-and-end answer with every data field cleared.
    function automatic t_result empty_result(input t_status st);
        t_result res;
        res = '{status: st, next_handle: '0, kind: KIND_START_END, offset: '0,
                length: '0, crc_present: 1'b0, crc: '0};
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/mts_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/mts_alu.sv]
// Shared 32-bit add/subtract unit with carry/borrow out.
// Depends on mts_pkg.
`default_nettype none

module mts_alu (
    input  wire mts_pkg::t_alu_req i_req,
    output mts_pkg::t_alu_rsp      o_rsp
);
    import mts_pkg::*;

    logic [32:0] wide;

    always_comb begin
        if (i_req.op == ALU_SUB) begin
            wide = {1'b0, i_req.a} - {1'b0, i_req.b};
        end else begin
            wide = {1'b0, i_req.a} + {1'b0, i_req.b};
        end
        o_rsp.sum   = wide[31:0];
        o_rsp.carry = wide[32];
    end

endmodule

`default_nettype wire

[rtl/multipart_transfer_sessions_top.sv]
// Multipart transfer session table: sequencer, session RAM and shared adder.
// Depends on mts_pkg, mts_ram and mts_alu.
//
// Serves a record table in fragments, one request at a time. A request with a
// zero handle and flag 1 starts a transfer: if the table fits in one chunk the
// answer is start-and-end, otherwise a session is allocated in an 8-entry
// table with a fresh handle (top bit set). A nonzero handle continues its
// session with a middle fragment or, once the rest plus the 4 CRC bytes fits
// in a chunk, an end fragment carrying table_crc. Expired sessions are dropped
// during the lookup scan. Handshake: o_in_ready is high only while the
// sequencer is idle, so a new request is taken only once the last one has
// been loaded into the output register. A bad-flag request goes from idle
// straight to the emit state, a single-chunk start after the fit check, and
// any request that touches the session table after a scan of every session
// entry and the steps that follow it; a middle fragment is the slowest case
// when the output is not stalled.
// The scan reads one session entry per cycle from the session RAM, and every
// compare and add (expiry check, remaining bytes, next offset, new expiry,
// handle counter) goes through one shared 32-bit adder, one operation per
// cycle. A finished response waits in the output register until taken; the
// next request can be accepted meanwhile but its response waits behind it.
// Configuration writes take effect at once and must only happen while idle.
`default_nettype none

module multipart_transfer_sessions_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [mts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [31:0]                     i_cfg_data,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [31:0]                     i_request_handle,
    input  wire logic [7:0]                      i_request_flag,
    input  wire logic [31:0]                     i_now_ms,
    // response channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [1:0]                           o_status,
    output logic [31:0]                          o_next_handle,
    output logic [2:0]                           o_fragment_kind,
    output logic [15:0]                          o_data_offset,
    output logic [11:0]                          o_data_length,
    output logic                                 o_crc_present,
    output logic [31:0]                          o_crc_value
);
    import mts_pkg::*;

    // configuration registers
    logic [15:0] r_tl;
    logic [11:0] r_cap;
    logic [31:0] r_timeout;
    logic [31:0] r_crc;

    // control state
    t_state                  r_state, n_state;
    logic [SESSION_ENTRIES-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]        r_scan_cnt, n_scan_cnt;
    logic                    r_chk, n_chk;
    logic                    r_found, n_found;
    logic [31:0]             r_counter, n_counter;
    logic                    r_out_valid, n_out_valid;

    // working registers of the current request
    logic [IDX_W-1:0]        r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]        r_slot, n_slot;
    logic [31:0]             r_handle, n_handle;
    logic [31:0]             r_now, n_now;
    logic [15:0]             r_off, n_off;
    logic [15:0]             r_rem, n_rem;
    logic [11:0]             r_len, n_len;
    t_result                 r_res, n_res;
    t_result                 r_out, n_out;

    // shared unit and session RAM
    t_alu_req                alu_req;
    t_alu_rsp                alu_rsp;
    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic [IDX_W-1:0]        ram_raddr;
    t_entry                  ram_wdata;
    t_entry                  ram_rdata;

    logic                    expired;
    logic                    live;
    logic                    is_new;

    mts_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    mts_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SESSION_ENTRIES)
    ) u_sessions (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign is_new = (r_handle == '0);

    // -------------------------------------------------------------------
    // Shared adder operands, chosen by sequencer state
    // -------------------------------------------------------------------
    always_comb begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
        unique case (r_state)
            S_FIT:     alu_req = '{op: ALU_SUB, a: {20'd0, r_cap}, b: {16'd0, r_tl}};
            // expiry <= now when no borrow
            S_SCAN:    alu_req = '{op: ALU_SUB, a: r_now, b: ram_rdata.expiry};
            S_NEW_CNT: alu_req = '{op: ALU_ADD, a: r_counter, b: 32'd1};
            S_NEW_EXP: alu_req = '{op: ALU_ADD, a: r_now, b: r_timeout};
            S_REM:     alu_req = '{op: ALU_SUB, a: {16'd0, r_tl}, b: {16'd0, r_off}};
            S_CMP:     alu_req = '{op: ALU_SUB, a: {20'd0, r_cap}, b: {16'd0, r_rem}};
            S_ADV:     alu_req = '{op: ALU_ADD, a: {16'd0, r_off}, b: {20'd0, r_len}};
            S_TOUCH:   alu_req = '{op: ALU_ADD, a: r_now, b: r_timeout};
            default:   alu_req = '{op: ALU_ADD, a: '0, b: '0};
        endcase
    end

    // -------------------------------------------------------------------
    // Sequencer: next state and RAM access
    // -------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_scan_cnt  = r_scan_cnt;
        n_chk       = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_found     = r_found;
        n_slot      = r_slot;
        n_counter   = r_counter;
        n_handle    = r_handle;
        n_now       = r_now;
        n_off       = r_off;
        n_rem       = r_rem;
        n_len       = r_len;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_raddr = r_scan_cnt[IDX_W-1:0];
        ram_wdata = '{handle: r_handle, offset: r_off, expiry: alu_rsp.sum};
        expired   = 1'b0;
        live      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_handle   = i_request_handle;
                    n_now      = i_now_ms;
                    n_found    = 1'b0;
                    n_scan_cnt = '0;
                    if (i_request_handle == '0 && i_request_flag != FLAG_GET_FIRST) begin
                        n_res   = empty_result(ST_BAD_FLAG);
                        n_state = S_EMIT;
                    end else if (i_request_handle == '0) begin
                        n_state = S_FIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // table_length <= chunk_capacity: whole table in one fragment
            S_FIT: begin
                if (!alu_rsp.carry) begin
                    n_res        = empty_result(ST_OK);
                    n_res.length = r_tl[11:0];
                    n_state      = S_EMIT;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // one RAM read issued per cycle, checked the cycle after
            S_SCAN: begin
                if (r_scan_cnt != CNT_W'(SESSION_ENTRIES)) begin
                    n_chk      = 1'b1;
                    n_chk_idx  = r_scan_cnt[IDX_W-1:0];
                    n_scan_cnt = r_scan_cnt + 1'b1;
                end
                if (r_chk) begin
                    expired = r_valid[r_chk_idx] && (ram_rdata.expiry != '0)
                              && !alu_rsp.carry;
                    live    = r_valid[r_chk_idx] && !expired;
                    if (expired) begin
                        n_valid[r_chk_idx] = 1'b0;
                    end
                    if (!r_found) begin
                        if (is_new && !live) begin
                            n_found = 1'b1;
                            n_slot  = r_chk_idx;
                        end else if (!is_new && live && ram_rdata.handle == r_handle) begin
                            n_found = 1'b1;
                            n_slot  = r_chk_idx;
                            n_off   = ram_rdata.offset;
                        end
                    end
                end else if (r_scan_cnt == CNT_W'(SESSION_ENTRIES)) begin
                    if (r_found) begin
                        n_state = is_new ? S_NEW_CNT : S_REM;
                    end else begin
                        n_res   = empty_result(is_new ? ST_NO_SESSION : ST_UNKNOWN_HANDLE);
                        n_state = S_EMIT;
                    end
                end
            end

            // bump handle counter, skipping zero
            S_NEW_CNT: begin
                n_counter = (alu_rsp.sum == '0) ? 32'd1 : alu_rsp.sum;
                n_state   = S_NEW_EXP;
            end

            S_NEW_EXP: begin
                ram_we    = 1'b1;
                ram_wdata = '{handle: r_counter | HANDLE_TOP_BIT, offset: {4'd0, r_cap},
                              expiry: alu_rsp.sum};
                n_valid[r_slot] = 1'b1;
                n_res = '{status: ST_OK, next_handle: r_counter | HANDLE_TOP_BIT,
                          kind: KIND_START, offset: '0, length: r_cap,
                          crc_present: 1'b0, crc: '0};
                n_state = S_EMIT;
            end

            // remaining bytes; nothing left answers an empty start-and-end
            S_REM: begin
                if (alu_rsp.carry || alu_rsp.sum == '0) begin
                    n_res   = empty_result(ST_OK);
                    n_state = S_EMIT;
                end else begin
                    n_rem   = alu_rsp.sum[15:0];
                    n_state = S_CMP;
                end
            end

            // cap - rem >= CRC bytes: end fragment; else clamp length
            S_CMP: begin
                if (!alu_rsp.carry && alu_rsp.sum >= 32'(CHECKSUM_BYTES)) begin
                    n_valid[r_slot] = 1'b0;
                    n_res = '{status: ST_OK, next_handle: '0, kind: KIND_END,
                              offset: r_off, length: r_rem[11:0],
                              crc_present: (r_crc != '0), crc: r_crc};
                    n_state = S_EMIT;
                end else begin
                    n_len   = alu_rsp.carry ? r_cap : r_rem[11:0];
                    n_state = S_ADV;
                end
            end

            S_ADV: begin
                n_off   = alu_rsp.sum[15:0];
                n_res   = '{status: ST_OK, next_handle: r_handle, kind: KIND_MIDDLE,
                            offset: r_off, length: r_len, crc_present: 1'b0, crc: '0};
                n_state = S_TOUCH;
            end

            // refresh expiry and write back the advanced offset
            S_TOUCH: begin
                ram_we  = 1'b1;
                n_state = S_EMIT;
            end

            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------------------
    // Control and configuration registers
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_scan_cnt  <= '0;
            r_chk       <= 1'b0;
            r_found     <= 1'b0;
            r_counter   <= 32'd1;
            r_out_valid <= 1'b0;
            r_tl        <= '0;
            r_cap       <= DEFAULT_CHUNK;
            r_timeout   <= DEFAULT_TIMEOUT;
            r_crc       <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_scan_cnt  <= n_scan_cnt;
            r_chk       <= n_chk;
            r_found     <= n_found;
            r_counter   <= n_counter;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TABLE_LENGTH:    r_tl      <= i_cfg_data[15:0];
                    CFG_CHUNK_CAPACITY:  r_cap     <= i_cfg_data[11:0];
                    CFG_SESSION_TIMEOUT: r_timeout <= i_cfg_data;
                    CFG_TABLE_CRC:       r_crc     <= i_cfg_data;
                    default:             r_crc     <= r_crc;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_chk_idx <= n_chk_idx;
        r_slot    <= n_slot;
        r_handle  <= n_handle;
        r_now     <= n_now;
        r_off     <= n_off;
        r_rem     <= n_rem;
        r_len     <= n_len;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_next_handle   = r_out.next_handle;
    assign o_fragment_kind = r_out.kind;
    assign o_data_offset   = r_out.offset;
    assign o_data_length   = r_out.length;
    assign o_crc_present   = r_out.crc_present;
    assign o_crc_value     = r_out.crc;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK
            |-> o_fragment_kind == KIND_START_END && o_next_handle == '0)
        else $error("error response with fragment or handle");

    a_mid_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fragment_kind == KIND_MIDDLE |-> o_next_handle[31])
        else $error("middle fragment without session handle");

    a_crc_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_crc_present
            |-> o_fragment_kind == KIND_END && o_crc_value != '0)
        else $error("CRC flagged outside end fragment");

    a_counter_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_counter != '0)
        else $error("handle counter reached zero");

endmodule

`default_nettype wire

[dv/tb_multipart_transfer_sessions_top.sv]
// Self-checking testbench for multipart_transfer_sessions_top: directed checks, then
// random request traffic under three handshake idling mixes, checked against a predictor.
// Depends on mts_pkg and the RTL under rtl/; needs no files or arguments.
`timescale 1ns / 1ps

module tb_multipart_transfer_sessions_top;
    import mts_pkg::*;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on either channel
    localparam int MAX_REPORTS    = 10;
    localparam int SETTINGS_BLOCK = 104;   // random requests between register changes

    // ------------------------------------------------------------------
    // DUT connections; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic                 i_clk;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index      = CFG_TABLE_LENGTH;
    logic [31:0]          i_cfg_data       = '0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_ready;
    logic [31:0]          i_request_handle = '0;
    logic [7:0]           i_request_flag   = '0;
    logic [31:0]          i_now_ms         = '0;
    logic                 o_out_valid;
    logic                 i_out_ready      = 1'b0;
    logic [1:0]           o_status;
    logic [31:0]          o_next_handle;
    logic [2:0]           o_fragment_kind;
    logic [15:0]          o_data_offset;
    logic [11:0]          o_data_length;
    logic                 o_crc_present;
    logic [31:0]          o_crc_value;

    multipart_transfer_sessions_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_request_handle (i_request_handle),
        .i_request_flag   (i_request_flag),
        .i_now_ms         (i_now_ms),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_next_handle    (o_next_handle),
        .o_fragment_kind  (o_fragment_kind),
        .o_data_offset    (o_data_offset),
        .o_data_length    (o_data_length),
        .o_crc_present    (o_crc_present),
        .o_crc_value      (o_crc_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF_NS i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and the session table
    // ------------------------------------------------------------------
    logic [15:0] cfg_table_length;
    logic [11:0] cfg_chunk;
    logic [31:0] cfg_timeout;
    logic [31:0] cfg_crc;

    logic [31:0] handle_count;
    logic [31:0] sess_handle [SESSION_ENTRIES];
    logic [15:0] sess_offset [SESSION_ENTRIES];
    logic [31:0] sess_expiry [SESSION_ENTRIES];
    bit          sess_live   [SESSION_ENTRIES];

    // Answers predicted at request acceptance, oldest first
    t_result     answers_due [$];
    t_result     latest_answer;

    // Handshake idling, in percent of cycles
    int          request_gap_pct  = 13;
    int          answer_stall_pct = 52;

    // Stimulus time base (ms); wraps at 32 bits like the real uptime
    logic [31:0] clock_ms = '0;

    int          fault_count      = 0;
    int          requests_sent    = 0;
    int          answers_checked  = 0;
    int          settings_applied = 0;
    int          answer_tally   [4];
    int          fragment_tally [8];
    int          quiet_cycles     = 0;

    // Sessions whose expiry is at or before now are released. Zero expiry never expires.
    function automatic void drop_stale(input logic [31:0] now);
        for (int i = 0; i < SESSION_ENTRIES; i++)
            if (sess_live[i] && sess_expiry[i] != '0 && sess_expiry[i] <= now)
                sess_live[i] = 1'b0;
    endfunction

    // Works out the answer to one request and advances the session table.
    function automatic t_result serve_request(input logic [31:0] handle,
                                              input logic [7:0]  flag,
                                              input logic [31:0] now);
        t_result     res;
        int          slot;
        logic [31:0] remaining;
        logic [11:0] take;
        slot = -1;
        res  = '{status: ST_OK, next_handle: '0, kind: KIND_START_END, offset: '0,
                 length: '0, crc_present: 1'b0, crc: '0};

        if (handle == '0) begin
            // bad flag and single-chunk answers leave the table untouched
            if (flag != FLAG_GET_FIRST) begin
                res.status = ST_BAD_FLAG;
                return res;
            end
            if (cfg_table_length <= cfg_chunk) begin
                res.length = cfg_table_length[11:0];
                return res;
            end
            drop_stale(now);
            for (int i = 0; i < SESSION_ENTRIES; i++)
                if (!sess_live[i]) begin
                    slot = i;
                    break;
                end
            if (slot < 0) begin
                res.status = ST_NO_SESSION;
                return res;
            end
            handle_count = handle_count + 32'd1;
            if (handle_count == '0)
                handle_count = 32'd1;
            sess_handle[slot] = handle_count | HANDLE_TOP_BIT;
            sess_offset[slot] = {4'h0, cfg_chunk};
            sess_expiry[slot] = now + cfg_timeout;
            sess_live[slot]   = 1'b1;
            res.next_handle   = sess_handle[slot];
            res.kind          = KIND_START;
            res.length        = cfg_chunk;
            return res;
        end

        // continuation: the flag plays no part
        drop_stale(now);
        for (int i = 0; i < SESSION_ENTRIES; i++)
            if (sess_live[i] && sess_handle[i] == handle) begin
                slot = i;
                break;
            end
        if (slot < 0) begin
            res.status = ST_UNKNOWN_HANDLE;
            return res;
        end
        remaining = (sess_offset[slot] < cfg_table_length) ?
                    {16'h0, cfg_table_length - sess_offset[slot]} : '0;
        if (remaining == '0)
            return res;  // nothing left; session stays open
        if (remaining + CHECKSUM_BYTES <= cfg_chunk) begin
            sess_live[slot] = 1'b0;
            res.kind        = KIND_END;
            res.offset      = sess_offset[slot];
            res.length      = remaining[11:0];
            res.crc_present = (cfg_crc != '0);
            res.crc         = cfg_crc;
            return res;
        end
        take              = (cfg_chunk < remaining) ? cfg_chunk : remaining[11:0];
        res.kind          = KIND_MIDDLE;
        res.next_handle   = handle;
        res.offset        = sess_offset[slot];
        res.length        = take;
        sess_offset[slot] = sess_offset[slot] + {4'h0, take};
        sess_expiry[slot] = now + cfg_timeout;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Presents one request and holds it until accepted. Valid is only dropped
    // for an idle gap, so it never toggles twice in one time step.
    task automatic send_request(input logic [31:0] handle, input logic [7:0] flag,
                                input logic [31:0] now);
        if ($urandom_range(0, 99) < request_gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < request_gap_pct);
        end
        i_in_valid       <= 1'b1;
        i_request_handle <= handle;
        i_request_flag   <= flag;
        i_now_ms         <= now;
        do @(posedge i_clk); while (!o_in_ready);
        latest_answer = serve_request(handle, flag, now);
        answers_due.push_back(latest_answer);
        requests_sent++;
        answer_tally[latest_answer.status]++;
        if (latest_answer.status == ST_OK)
            fragment_tally[latest_answer.kind]++;
    endtask

    // Stops requests and waits until the block is idle again.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on back-to-back cycles; only called while idle.
    task automatic apply_settings(input logic [15:0] len, input logic [11:0] cap,
                                  input logic [31:0] tmo, input logic [31:0] crc);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TABLE_LENGTH;
        i_cfg_data  <= {16'h0, len};
        @(posedge i_clk);
        i_cfg_index <= CFG_CHUNK_CAPACITY;
        i_cfg_data  <= {20'h0, cap};
        @(posedge i_clk);
        i_cfg_index <= CFG_SESSION_TIMEOUT;
        i_cfg_data  <= tmo;
        @(posedge i_clk);
        i_cfg_index <= CFG_TABLE_CRC;
        i_cfg_data  <= crc;
        @(posedge i_clk);
        i_cfg_we         <= 1'b0;
        cfg_table_length = len;
        cfg_chunk        = cap;
        cfg_timeout      = tmo;
        cfg_crc          = crc;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Answer side: random back-pressure and the scoreboard
    // ------------------------------------------------------------------
    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= answer_stall_pct);

    always @(posedge i_clk) begin : check_answers
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (answers_due.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("[%0t] answer with no request pending: status %0d handle %h",
                             $realtime, o_status, o_next_handle);
            end else begin
                want = answers_due.pop_front();
                answers_checked++;
                if (o_status !== want.status || o_next_handle !== want.next_handle ||
                    o_fragment_kind !== want.kind || o_data_offset !== want.offset ||
                    o_data_length !== want.length || o_crc_present !== want.crc_present ||
                    o_crc_value !== want.crc) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS) begin
                        $display("[%0t] answer %0d mismatch", $realtime, answers_checked);
                        $display("  want st=%0d nh=%h kind=%0d off=%0d len=%0d crc=%b/%h",
                                 want.status, want.next_handle, want.kind, want.offset,
                                 want.length, want.crc_present, want.crc);
                        $display("  got  st=%0d nh=%h kind=%0d off=%0d len=%0d crc=%b/%h",
                                 o_status, o_next_handle, o_fragment_kind, o_data_offset,
                                 o_data_length, o_crc_present, o_crc_value);
                    end
                end
            end
        end
    end

    // Ends a hung run: no request and no answer moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d answers outstanding",
                     WATCHDOG_LIMIT, answers_due.size());
            $display("tb_multipart_transfer_sessions_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Register defaults: empty table answered whole, bad flag, never-issued handle.
    task automatic test_reset_defaults();
        send_request('0, FLAG_GET_FIRST, 32'd10);
        send_request('0, 8'hFE, 32'd11);
        send_request(HANDLE_TOP_BIT | 32'd2, 8'h00, 32'd12);
    endtask

    // Table exactly one chunk: start-and-end, and no CRC even though one is set.
    task automatic test_single_chunk();
        settle();
        apply_settings(16'd56, 12'd56, DEFAULT_TIMEOUT, 32'hDEAD_BEEF);
        send_request('0, FLAG_GET_FIRST, 32'd20);
    endtask

    // Full walk through one session, including the nothing-left answer and a
    // table that grows under a live session.
    task automatic test_transfer_walk();
        logic [31:0] h;
        settle();
        apply_settings(16'd298, 12'd100, DEFAULT_TIMEOUT, 32'hFFFF_FFFF);
        send_request('0, FLAG_GET_FIRST, 32'd100);
        h = latest_answer.next_handle;
        send_request(h, 8'h00, 32'd110);            // middle, offset 100
        send_request(h, 8'hFF, 32'd120);            // last 98 bytes, CRC does not fit
        send_request(h, FLAG_GET_FIRST, 32'd130);   // offset at the end: empty answer
        settle();
        apply_settings(16'd350, 12'd100, DEFAULT_TIMEOUT, 32'hFFFF_FFFF);
        send_request(h, 8'h5A, 32'd140);            // 52 more bytes: end with CRC
        send_request(h, 8'h00, 32'd150);            // retired handle
    endtask

    // Expiry boundaries: refresh one ms early, drop on equality, and a wrapped
    // expiry of zero that never runs out. Ends on a CRC-less end fragment.
    task automatic test_session_expiry();
        logic [31:0] h;
        settle();
        apply_settings(16'd200, 12'd64, 32'd100, '0);
        send_request('0, FLAG_GET_FIRST, 32'd1000);
        h = latest_answer.next_handle;
        send_request(h, 8'h00, 32'd1099);
        send_request(h, 8'h00, 32'd1199);
        settle();
        apply_settings(16'd200, 12'd64, 32'd1, '0);
        send_request('0, FLAG_GET_FIRST, 32'hFFFF_FFFF);
        h = latest_answer.next_handle;
        send_request(h, 8'h00, 32'd5);
        send_request(h, 8'h00, 32'd5);
        send_request(h, 8'h00, 32'd5);
    endtask

    // Fill every entry, overflow once, then let all of them expire.
    task automatic test_table_full();
        settle();
        apply_settings(16'd1000, 12'd10, 32'd500, 32'hFFFF_FFFF);
        repeat (SESSION_ENTRIES + 1) send_request('0, FLAG_GET_FIRST, 32'd2000);
        send_request('0, FLAG_GET_FIRST, 32'd2500);
    endtask

    // Zero chunk capacity gives empty fragments that never advance.
    task automatic test_zero_capacity();
        logic [31:0] h;
        settle();
        apply_settings(16'd10, 12'd0, DEFAULT_TIMEOUT, '0);
        send_request('0, FLAG_GET_FIRST, 32'd3000);
        h = latest_answer.next_handle;
        send_request(h, 8'h00, 32'd3001);
    endtask

    // Widest table, widest chunk, largest timeout and CRC.
    task automatic test_extremes();
        logic [31:0] h;
        settle();
        apply_settings(16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request('0, FLAG_GET_FIRST, 32'd0);
        h = latest_answer.next_handle;
        send_request(h, 8'hFF, 32'd1);
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly continuations of open sessions, plus starts,
    // bad flags, near-miss handles and pure noise; registers change per block.
    // ------------------------------------------------------------------
    task automatic run_random_traffic(input int items, input int req_gap, input int ans_gap);
        logic [31:0] live_handles [$];
        logic [31:0] handle;
        logic [7:0]  flag;
        logic [31:0] tmo;
        logic [31:0] crc;
        int          roll;
        int          cap;
        int          len;
        request_gap_pct  = req_gap;
        answer_stall_pct = ans_gap;
        for (int n = 0; n < items; n++) begin
            if (n % SETTINGS_BLOCK == 0) begin
                settle();
                roll = $urandom_range(0, 99);
                if (roll < 12)      cap = 1;
                else if (roll < 24) cap = 4095;
                else if (roll < 32) cap = $urandom_range(1, 8);
                else                cap = $urandom_range(9, 400);
                roll = $urandom_range(0, 99);
                if (roll < 8)       len = 0;
                else if (roll < 16) len = 65535;
                else if (roll < 28) len = $urandom_range(0, cap);
                else                len = cap * $urandom_range(1, 5) + $urandom_range(0, cap);
                roll = $urandom_range(0, 99);
                if (roll < 10)      tmo = 32'd1;
                else if (roll < 20) tmo = 32'hFFFF_FFFF;
                else if (roll < 30) tmo = DEFAULT_TIMEOUT;
                else                tmo = $urandom_range(50, 5000);
                roll = $urandom_range(0, 99);
                if (roll < 20)      crc = '0;
                else if (roll < 40) crc = 32'hFFFF_FFFF;
                else                crc = $urandom;
                apply_settings(16'(len), 12'(cap), tmo, crc);
            end

            // time mostly creeps forward, sometimes leaps past timeouts or anywhere
            roll = $urandom_range(0, 99);
            if (roll < 4)       clock_ms = $urandom;
            else if (roll < 14) clock_ms = clock_ms + $urandom_range(0, 20000);
            else                clock_ms = clock_ms + $urandom_range(0, 40);

            live_handles.delete();
            foreach (sess_live[i])
                if (sess_live[i])
                    live_handles.push_back(sess_handle[i]);

            roll = $urandom_range(0, 99);
            flag = 8'($urandom);
            if (roll < 62 && live_handles.size() != 0) begin
                handle = live_handles[$urandom_range(0, live_handles.size() - 1)];
            end else if (roll < 80) begin
                handle = '0;
                flag   = FLAG_GET_FIRST;
            end else if (roll < 87) begin
                handle = '0;
                if (flag == FLAG_GET_FIRST)
                    flag = ~flag;
            end else if (roll < 94) begin
                // close to issued handles: retired, open or not yet issued
                handle = (handle_count + $urandom_range(0, 24) - 32'd20) | HANDLE_TOP_BIT;
            end else begin
                handle = $urandom;
            end
            send_request(handle, flag, clock_ms);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // predictor follows the block's reset state
        cfg_table_length = '0;
        cfg_chunk        = DEFAULT_CHUNK;
        cfg_timeout      = DEFAULT_TIMEOUT;
        cfg_crc          = '0;
        handle_count     = 32'd1;
        foreach (sess_live[i]) begin
            sess_live[i]   = 1'b0;
            sess_handle[i] = '0;
            sess_offset[i] = '0;
            sess_expiry[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_single_chunk();
        test_transfer_walk();
        test_session_expiry();
        test_table_full();
        test_zero_capacity();
        test_extremes();

        // sender lightly idle / receiver stalling, then swapped, then full rate
        run_random_traffic(417, 13, 52);
        run_random_traffic(417, 52, 13);
        run_random_traffic(416, 0, 0);

        settle();
        fault_count += answers_due.size();

        $display("ran %0d requests under %0d register settings, %0d answers compared",
                 requests_sent, settings_applied, answers_checked);
        $display("ok %0d, bad flag %0d, unknown handle %0d, table full %0d; %s %0d/%0d/%0d/%0d",
                 answer_tally[ST_OK], answer_tally[ST_BAD_FLAG],
                 answer_tally[ST_UNKNOWN_HANDLE], answer_tally[ST_NO_SESSION],
                 "start/middle/end/whole", fragment_tally[KIND_START],
                 fragment_tally[KIND_MIDDLE], fragment_tally[KIND_END],
                 fragment_tally[KIND_START_END]);
        if (fault_count == 0)
            $display("tb_multipart_transfer_sessions_top OK");
        else
            $display("tb_multipart_transfer_sessions_top NOT OK");
        $finish;
    end

endmodule

[sim.f]
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/mts_alu.sv
rtl/multipart_transfer_sessions_top.sv
dv/tb_multipart_transfer_sessions_top.sv
